// ===== rtl/core/rrd_pkg.sv =====
// Shared types and constants for the receive ring deframer.
`timescale 1ns / 1ps

package rrd_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned OFFSET_W = 14;
  localparam int unsigned CAPR_W   = 16;
  localparam int unsigned HDR_LEN_W = 16;

  // Defaults and fixed values
  localparam int unsigned RING_BYTES_DEF = 8192;
  localparam logic [LEN_W-1:0]  MAX_LEN_RESET = LEN_W'(1522);
  localparam logic [CAPR_W-1:0] CAPR_BACKOFF  = CAPR_W'(16);
  localparam logic [LEN_W-1:0]  CRC_BYTES     = LEN_W'(4);
  localparam logic [1:0]        HDR_LAST_BYTE = 2'd3;

  // Parser phase, one-hot
  typedef enum logic [1:0] {
    PH_HEADER = 2'b01,
    PH_BODY   = 2'b10
  } phase_t;

  // One result item
  typedef struct packed {
    logic                frame_valid;
    logic [BYTE_W-1:0]   frame_byte;
    logic                frame_last;
    logic                packet_done;
    logic [LEN_W-1:0]    frame_length;
    logic                ring_error;
    logic [CAPR_W-1:0]   capr_value;
    logic [OFFSET_W-1:0] read_offset;
  } result_t;

endpackage

// ===== rtl/core/rrd_if.sv =====
// Channel interfaces: ring byte input and deframed result output.
`timescale 1ns / 1ps

interface rrd_in_if import rrd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] ring_byte;

  modport source (output valid, output ring_byte, input ready);
  modport sink   (input valid, input ring_byte, output ready);
endinterface

interface rrd_out_if import rrd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                frame_valid;
  logic [BYTE_W-1:0]   frame_byte;
  logic                frame_last;
  logic                packet_done;
  logic [LEN_W-1:0]    frame_length;
  logic                ring_error;
  logic [CAPR_W-1:0]   capr_value;
  logic [OFFSET_W-1:0] read_offset;

  modport source (output valid, output frame_valid, output frame_byte, output frame_last,
                  output packet_done, output frame_length, output ring_error,
                  output capr_value, output read_offset, input ready);
  modport sink   (input valid, input frame_valid, input frame_byte, input frame_last,
                  input packet_done, input frame_length, input ring_error,
                  input capr_value, input read_offset, output ready);
endinterface

// ===== rtl/core/rrd_parser.sv =====
// Header/body parser: per-byte state update and result computation.
`timescale 1ns / 1ps

module rrd_parser import rrd_pkg::*; #(
  parameter int unsigned RING_BYTES = RING_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_wr_data,
  input  logic              acc,
  input  logic [BYTE_W-1:0] ring_byte,
  output result_t           res
);

  localparam int unsigned SUM_W = OFFSET_W + 1;
  localparam logic [SUM_W-1:0] RING1 = SUM_W'(RING_BYTES);
  localparam logic [SUM_W-1:0] RING2 = SUM_W'(2 * RING_BYTES);
  localparam logic [SUM_W-1:0] RING3 = SUM_W'(3 * RING_BYTES);

  logic [LEN_W-1:0]    max_len_r;
  phase_t              phase_r, phase_nxt;
  logic [1:0]          hdr_cnt_r, hdr_cnt_nxt;
  logic                stat_ok_r, stat_ok_nxt;
  logic [BYTE_W-1:0]   len_lo_r, len_lo_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [LEN_W-1:0]    body_cnt_r, body_cnt_nxt;
  logic [OFFSET_W-1:0] pkt_start_r, pkt_start_nxt;
  logic [OFFSET_W-1:0] rd_pos_r, rd_pos_nxt;

  logic [HDR_LEN_W-1:0] hdr_len;
  logic                 hdr_bad;
  logic [LEN_W-1:0]     payload;
  logic [LEN_W-1:0]     body_n;
  logic [SUM_W-1:0]     end_sum;
  logic [SUM_W-1:0]     end_algn;
  logic [OFFSET_W-1:0]  next_start;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // Header checks
  assign hdr_len = {ring_byte, len_lo_r};
  assign hdr_bad = !stat_ok_r || (hdr_len < HDR_LEN_W'(4)) ||
                   (hdr_len > HDR_LEN_W'(max_len_r));

  // Body counting
  assign payload = len_r - CRC_BYTES;
  assign body_n  = body_cnt_r + LEN_W'(1);

  // Next packet start: round up to 4, wrap at ring size (start is below ring size)
  assign end_sum  = SUM_W'(pkt_start_r) + SUM_W'(len_r) + SUM_W'(7);
  assign end_algn = end_sum & ~SUM_W'(3);
  always_comb begin
    if (end_algn >= RING3) begin
      next_start = OFFSET_W'(end_algn - RING3);
    end else if (end_algn >= RING2) begin
      next_start = OFFSET_W'(end_algn - RING2);
    end else if (end_algn >= RING1) begin
      next_start = OFFSET_W'(end_algn - RING1);
    end else begin
      next_start = OFFSET_W'(end_algn);
    end
  end

  // Per-byte step
  always_comb begin
    phase_nxt     = phase_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    stat_ok_nxt   = stat_ok_r;
    len_lo_nxt    = len_lo_r;
    len_nxt       = len_r;
    body_cnt_nxt  = body_cnt_r;
    pkt_start_nxt = pkt_start_r;
    rd_pos_nxt    = rd_pos_r;
    res           = '0;
    case (phase_r)
      PH_HEADER: begin
        rd_pos_nxt  = rd_pos_r + OFFSET_W'(1);
        hdr_cnt_nxt = hdr_cnt_r + 2'd1;
        case (hdr_cnt_r)
          2'd0: begin
            pkt_start_nxt = rd_pos_r;
            stat_ok_nxt   = ring_byte[0];
          end
          2'd2: len_lo_nxt = ring_byte;
          HDR_LAST_BYTE: begin
            if (hdr_bad) begin
              rd_pos_nxt     = '0;
              res.ring_error = 1'b1;
              res.capr_value = CAPR_W'(0) - CAPR_BACKOFF;
            end else begin
              phase_nxt    = PH_BODY;
              body_cnt_nxt = '0;
              len_nxt      = hdr_len[LEN_W-1:0];
            end
          end
          default: ;
        endcase
      end
      PH_BODY: begin
        body_cnt_nxt = body_n;
        if (body_n <= payload) begin
          res.frame_valid = 1'b1;
          res.frame_byte  = ring_byte;
          res.frame_last  = (body_n == payload);
        end
        if (body_n >= len_r) begin
          rd_pos_nxt       = next_start;
          phase_nxt        = PH_HEADER;
          body_cnt_nxt     = '0;
          res.packet_done  = 1'b1;
          res.frame_length = payload;
          res.capr_value   = CAPR_W'(next_start) - CAPR_BACKOFF;
        end else begin
          rd_pos_nxt = rd_pos_r + OFFSET_W'(1);
        end
      end
      default: begin
        phase_nxt   = PH_HEADER;
        hdr_cnt_nxt = '0;
      end
    endcase
    res.read_offset = rd_pos_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      hdr_cnt_r   <= '0;
      stat_ok_r   <= 1'b0;
      len_lo_r    <= '0;
      len_r       <= '0;
      body_cnt_r  <= '0;
      pkt_start_r <= '0;
      rd_pos_r    <= '0;
    end else if (acc) begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      stat_ok_r   <= stat_ok_nxt;
      len_lo_r    <= len_lo_nxt;
      len_r       <= len_nxt;
      body_cnt_r  <= body_cnt_nxt;
      pkt_start_r <= pkt_start_nxt;
      rd_pos_r    <= rd_pos_nxt;
    end
  end

  // Assertions
  a_done_back_to_header: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res.packet_done) |=> (phase_r == PH_HEADER && hdr_cnt_r == 2'd0))
    else $error("packet end did not return to header phase");

  a_error_resets_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res.ring_error) |=> (rd_pos_r == '0 && phase_r == PH_HEADER))
    else $error("bad header did not reset read offset");

  a_last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    res.frame_last |-> (res.frame_valid && phase_r == PH_BODY))
    else $error("frame_last without a payload byte");

  a_body_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (body_cnt_r < len_r && len_r >= CRC_BYTES))
    else $error("body count past packet length");

endmodule

// ===== rtl/core/rrd_out_buf.sv =====
// Two-entry result buffer: output register plus skid stage.
`timescale 1ns / 1ps

module rrd_out_buf import rrd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  result_t push_data,
  output logic    pop_valid,
  input  logic    pop_ready,
  output result_t pop_data
);

  logic    main_v_r, main_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t main_d_r;
  result_t skid_d_r;
  logic    push, pop;
  logic    load_main, load_skid;

  assign push_ready = !skid_v_r;
  assign push       = push_valid && push_ready;
  assign pop        = main_v_r && pop_ready;
  assign pop_valid  = main_v_r;
  assign pop_data   = main_d_r;

  // Occupancy control
  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    load_main  = 1'b0;
    load_skid  = 1'b0;
    if (!main_v_r || pop) begin
      load_main  = 1'b1;
      main_v_nxt = skid_v_r || push;
      skid_v_nxt = 1'b0;
    end else if (push) begin
      load_skid  = 1'b1;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (load_main) begin
      main_d_r <= skid_v_r ? skid_d_r : push_data;
    end
    if (load_skid) begin
      skid_d_r <= push_data;
    end
  end

  // Assertions
  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid stage holds an item while output register is empty");

  a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (main_v_r && !pop_ready) |=> (main_v_r && main_d_r == $past(main_d_r)))
    else $error("stalled result changed");

  a_skid_drains_first: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && pop) |=> (main_d_r == $past(skid_d_r)))
    else $error("skid item not moved to output register");

endmodule

// ===== rtl/core/receive_ring_deframer_top.sv =====
// Top level of the receive ring deframer.
// Takes one ring byte per clock when in_ch.ready is high and returns one
// result item per byte, in order. Each byte is parsed in a single pass
// between the parser state registers and the result register, so a byte is
// accepted each such cycle. A two-entry output buffer (output register
// plus skid stage) lets the block keep accepting bytes while a finished
// result waits; in_ch.ready drops only when both entries are full. The
// user must write max_packet_length via cfg_wr_en / cfg_wr_data only while
// the block is idle (not enforced). There is no clearing pass after reset.
`timescale 1ns / 1ps

module receive_ring_deframer_top import rrd_pkg::*; #(
  parameter int unsigned RING_BYTES = RING_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  rrd_in_if.sink           in_ch,
  rrd_out_if.source        out_ch
);

  result_t step_res;
  result_t out_res;
  logic    buf_ready;
  logic    acc;

  assign in_ch.ready = buf_ready;
  assign acc         = in_ch.valid && buf_ready;

  // Byte parser
  rrd_parser #(
    .RING_BYTES (RING_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .acc         (acc),
    .ring_byte   (in_ch.ring_byte),
    .res         (step_res)
  );

  // Result buffer
  rrd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_ch.valid),
    .push_ready (buf_ready),
    .push_data  (step_res),
    .pop_valid  (out_ch.valid),
    .pop_ready  (out_ch.ready),
    .pop_data   (out_res)
  );

  // Unpack onto the result channel
  assign out_ch.frame_valid  = out_res.frame_valid;
  assign out_ch.frame_byte   = out_res.frame_byte;
  assign out_ch.frame_last   = out_res.frame_last;
  assign out_ch.packet_done  = out_res.packet_done;
  assign out_ch.frame_length = out_res.frame_length;
  assign out_ch.ring_error   = out_res.ring_error;
  assign out_ch.capr_value   = out_res.capr_value;
  assign out_ch.read_offset  = out_res.read_offset;

endmodule
